>>> design/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

  // configuration register
  localparam int unsigned OFFSET_W          = 4;
  localparam int unsigned MAX_OFFSET_BITS   = 12;
  localparam int unsigned LINE_OFFSET_RESET = 6;

  // result fields
  localparam int unsigned WAY_OUT_W = 3;
  localparam int unsigned CNT_W     = 32;

endpackage : sacl_pkg

`default_nettype wire

>>> design/sacl_if.sv
`default_nettype none

// lookup request channel
interface sacl_req_if #(
  parameter int unsigned ADDR_W = 48
);
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface : sacl_req_if

// lookup result channel
interface sacl_rsp_if;
  import sacl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way_used;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;

  modport source (output valid, output hit, output way_used, output hit_total,
                  output miss_total, input ready);
  modport sink   (input valid, input hit, input way_used, input hit_total,
                  input miss_total, output ready);
endinterface : sacl_rsp_if

// line size register write channel
interface sacl_cfg_if;
  import sacl_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] line_offset_bits;

  modport source (output valid, output line_offset_bits, input ready);
  modport sink   (input valid, input line_offset_bits, output ready);
endinterface : sacl_cfg_if

`default_nettype wire

>>> design/set_assoc_lru_cache_lookup_core.sv
// pipeline: an accepted request is registered in stage 1 with its memory rows, then moves
//   into the result register when that register is empty or its beat is being taken
// throughput: one lookup per cycle while result beats are taken; tag, valid and rank rows
//   are read from memory at accept, with the row written back by the previous lookup
//   forwarded into the read register; reset clears hit and miss totals and pipeline valids
//   at once, sets line offset to 6, clears valid rows one set per cycle while requests wait
`default_nettype none

module set_assoc_lru_cache_lookup_core #(
  parameter int unsigned WAYS      = 8,
  parameter int unsigned SETS      = 64,
  parameter int unsigned ADDR_BITS = 48
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  sacl_req_if.sink     req_i,
  sacl_rsp_if.source   rsp_o,
  sacl_cfg_if.sink     cfg_i
);
  import sacl_pkg::*;

  localparam int unsigned SET_BITS = $clog2(SETS);
  localparam int unsigned SET_W    = (SETS > 1) ? SET_BITS : 1;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TAG_W    = ADDR_BITS - SET_BITS;
  localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);

  // configuration
  logic [OFFSET_W-1:0] line_offset_bits_q;

  // stage 1: registered request and memory rows
  logic                            s1_valid_q;
  logic [SET_W-1:0]                s1_set_q;
  logic [TAG_W-1:0]                s1_tag_q;
  logic [WAYS-1:0][TAG_W-1:0]      tag_row_q;
  logic [WAYS-1:0][WAY_W-1:0]      rank_row_q;
  logic [WAYS-1:0]                 valid_row_q;

  // storage
  logic [WAYS-1:0][TAG_W-1:0]      tag_mem   [SETS];
  logic [WAYS-1:0][WAY_W-1:0]      rank_mem  [SETS];
  logic [WAYS-1:0]                 valid_mem [SETS];

  // valid row clearing after reset
  logic                 clr_active_q;
  logic [SET_W-1:0]     clr_idx_q;

  // result register
  logic                 out_valid_q;
  logic                 hit_q;
  logic [WAY_OUT_W-1:0] way_q;
  logic [CNT_W-1:0]     hit_count_q, hit_count_d;
  logic [CNT_W-1:0]     miss_count_q, miss_count_d;

  // request split
  logic [OFFSET_W-1:0]  shift_amt;
  logic [ADDR_BITS-1:0] line_in;
  logic [SET_W-1:0]     set_in;
  logic [TAG_W-1:0]     tag_in;

  // handshake
  logic fire;
  logic accept;
  logic fwd;

  // lookup and update
  logic [WAYS-1:0]            row_valid;
  logic [WAYS-1:0][WAY_W-1:0] rank_eff;
  logic                       hit;
  logic                       found_inv;
  logic [WAY_W-1:0]           hit_way;
  logic [WAY_W-1:0]           inv_way;
  logic [WAY_W-1:0]           lru_way;
  logic [WAY_W-1:0]           way_sel;
  logic [WAYS-1:0]            way_onehot;
  logic                       was_valid;
  logic [WAY_W-1:0]           old_rank;
  logic [WAY_W-1:0]           others;
  logic [WAYS-1:0]            valid_row_d;
  logic [WAYS-1:0][WAY_W-1:0] rank_row_d;
  logic [WAYS-1:0][TAG_W-1:0] tag_row_d;

  assign shift_amt = (line_offset_bits_q > OFFSET_W'(MAX_OFFSET_BITS)) ?
                     OFFSET_W'(MAX_OFFSET_BITS) : line_offset_bits_q;
  assign line_in   = req_i.address >> shift_amt;
  assign set_in    = SET_W'(line_in) & SET_MASK;
  assign tag_in    = TAG_W'(line_in >> SET_BITS);

  assign fire        = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clr_active_q && (!s1_valid_q || fire);
  assign accept      = req_i.valid && req_i.ready;
  assign fwd         = fire && (s1_set_q == set_in);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    row_valid = valid_row_q;
    hit       = 1'b0;
    found_inv = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    lru_way   = '0;
    // ways never filled read as rank zero
    for (int i = 0; i < WAYS; i++) begin
      rank_eff[i] = row_valid[i] ? rank_row_q[i] : '0;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && row_valid[i] && (tag_row_q[i] == s1_tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (!found_inv && !row_valid[i]) begin
        found_inv = 1'b1;
        inv_way   = WAY_W'(i);
      end
    end
    // ranks of a full set are unique, so rank zero marks the lru way
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rank_eff[i] == '0) begin
        lru_way = WAY_W'(i);
      end
    end

    priority if (hit) begin
      way_sel = hit_way;
    end else if (found_inv) begin
      way_sel = inv_way;
    end else begin
      way_sel = lru_way;
    end

    way_onehot = '0;
    way_onehot[way_sel] = 1'b1;
    was_valid = row_valid[way_sel];
    old_rank  = rank_eff[way_sel];
    others    = WAY_W'($countones(row_valid & ~way_onehot));

    for (int i = 0; i < WAYS; i++) begin
      if (way_onehot[i]) begin
        rank_row_d[i] = others;
      end else if (row_valid[i] && was_valid && (rank_eff[i] > old_rank)) begin
        rank_row_d[i] = rank_eff[i] - WAY_W'(1);
      end else begin
        rank_row_d[i] = rank_eff[i];
      end
    end
    valid_row_d = row_valid | way_onehot;

    tag_row_d = tag_row_q;
    if (!hit) begin
      tag_row_d[way_sel] = s1_tag_q;
    end

    hit_count_d  = hit_count_q;
    miss_count_d = miss_count_q;
    if (hit) begin
      if (hit_count_q != '1) hit_count_d = hit_count_q + CNT_W'(1);
    end else begin
      if (miss_count_q != '1) miss_count_d = miss_count_q + CNT_W'(1);
    end
  end

  // row memories, read at accept with write-first forwarding
  always_ff @(posedge clk_i) begin
    if (fire) begin
      tag_mem[s1_set_q]  <= tag_row_d;
      rank_mem[s1_set_q] <= rank_row_d;
    end
    if (clr_active_q) begin
      valid_mem[clr_idx_q] <= '0;
    end else if (fire) begin
      valid_mem[s1_set_q] <= valid_row_d;
    end
    if (accept) begin
      s1_set_q    <= set_in;
      s1_tag_q    <= tag_in;
      tag_row_q   <= fwd ? tag_row_d   : tag_mem[set_in];
      rank_row_q  <= fwd ? rank_row_d  : rank_mem[set_in];
      valid_row_q <= fwd ? valid_row_d : valid_mem[set_in];
    end
    if (fire) begin
      hit_q <= hit;
      way_q <= WAY_OUT_W'(way_sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_offset_bits_q <= OFFSET_W'(LINE_OFFSET_RESET);
      s1_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      hit_count_q        <= '0;
      miss_count_q       <= '0;
      clr_active_q       <= 1'b1;
      clr_idx_q          <= '0;
    end else begin
      if (clr_active_q) begin
        clr_idx_q <= clr_idx_q + SET_W'(1);
        if (clr_idx_q == SET_W'(SETS - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      if (cfg_i.valid) begin
        line_offset_bits_q <= cfg_i.line_offset_bits;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q         <= 1'b1;
        hit_count_q         <= hit_count_d;
        miss_count_q        <= miss_count_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // totals change only when a new result is loaded into the result register
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = hit_q;
  assign rsp_o.way_used   = way_q;
  assign rsp_o.hit_total  = hit_count_q;
  assign rsp_o.miss_total = miss_count_q;

endmodule : set_assoc_lru_cache_lookup_core

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sacl_pkg::*;

  localparam int unsigned WAYS      = 8;
  localparam int unsigned SETS      = 64;
  localparam int unsigned SET_BITS  = 6;
  localparam int unsigned ADDR_BITS = 48;
  localparam int unsigned PHASE_N   = 8;
  localparam int unsigned PHASE_LEN = 250;
  localparam int unsigned DIR_N     = 18;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
  } lookup_t;

  typedef struct {
    logic [ADDR_BITS-1:0] addr;
    bit                   typed;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  sacl_req_if #(.ADDR_W(ADDR_BITS)) req_if ();
  sacl_rsp_if rsp_if ();
  sacl_cfg_if cfg_if ();

  set_assoc_lru_cache_lookup_core #(
    .WAYS      (WAYS),
    .SETS      (SETS),
    .ADDR_BITS (ADDR_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // shadow of the tag directory
  logic [ADDR_BITS-1:0] tag_mem   [SETS][WAYS];
  bit                   way_valid [SETS][WAYS];
  int unsigned          way_rank  [SETS][WAYS];
  logic [CNT_W-1:0]     hit_cnt;
  logic [CNT_W-1:0]     miss_cnt;
  logic [OFFSET_W-1:0]  line_off;

  lookup_t pending_lookups[$];
  int unsigned mismatches;
  int unsigned seen_hits;
  int unsigned seen_misses;
  int unsigned settings_run;
  bit req_idle;
  bit rsp_idle;

  logic [ADDR_BITS-1:0] tag_pool [12];
  int unsigned hot_sets [4];
  logic [ADDR_BITS-1:0] last_addr;

  dir_row_t dir_rows [DIR_N] = '{
    '{48'h0000_0000_0000, 1'b1, 1'b0, 3'd0, 32'd0, 32'd1},
    '{48'h0000_0000_003F, 1'b1, 1'b1, 3'd0, 32'd1, 32'd1},
    '{48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd0, 32'd1, 32'd2},
    '{48'h8000_0000_0000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_0040, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_1000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_2000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_3000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_4000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_5000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_6000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_0020, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_7000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h8000_0000_0000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'hFFFF_FFFF_FFC0, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h5555_5555_5555, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
    '{48'h0000_0000_0FFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0}
  };

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_shift();
    return (line_off > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : int'(line_off);
  endfunction

  // look up one address in the shadow directory and update it
  function automatic lookup_t predict_lookup(logic [ADDR_BITS-1:0] addr);
    lookup_t              res;
    logic [ADDR_BITS-1:0] line;
    logic [ADDR_BITS-1:0] tg;
    int unsigned          s;
    int unsigned          w;
    int unsigned          others;
    int unsigned          old_rank;
    bit                   found;
    bit                   was_valid;
    line  = addr >> eff_shift();
    s     = int'(line[SET_BITS-1:0]);
    tg    = line >> SET_BITS;
    found = 1'b0;
    w     = 0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && way_valid[s][i] && tag_mem[s][i] == tg) begin
        found = 1'b1;
        w     = i;
      end
    end
    if (!found) begin
      bit have_free;
      have_free = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        if (!have_free && !way_valid[s][i]) begin
          have_free = 1'b1;
          w         = i;
        end
      end
      if (!have_free) begin
        w = 0;
        for (int i = 1; i < WAYS; i++)
          if (way_rank[s][i] < way_rank[s][w]) w = i;
      end
      tag_mem[s][w] = tg;
    end
    // promote way w to most recently used
    was_valid = way_valid[s][w];
    old_rank  = way_rank[s][w];
    others    = 0;
    for (int i = 0; i < WAYS; i++) begin
      if (i != w && way_valid[s][i]) begin
        others++;
        if (was_valid && way_rank[s][i] > old_rank) way_rank[s][i]--;
      end
    end
    way_rank[s][w]  = others;
    way_valid[s][w] = 1'b1;
    if (found) begin
      if (hit_cnt != '1) hit_cnt++;
    end else begin
      if (miss_cnt != '1) miss_cnt++;
    end
    res.hit    = found;
    res.way    = w[WAY_OUT_W-1:0];
    res.hits   = hit_cnt;
    res.misses = miss_cnt;
    return res;
  endfunction

  task automatic send_lookup(logic [ADDR_BITS-1:0] addr, bit typed, lookup_t typed_exp);
    int unsigned gap;
    lookup_t     pred;
    gap = req_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.address <= addr;
    do @(posedge clk_i); while (!req_if.ready);
    pred = predict_lookup(addr);
    pending_lookups.insert(pending_lookups.size(), typed ? typed_exp : pred);
    last_addr = addr;
  endtask

  task automatic drain_lookups();
    req_if.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_line_offset(logic [OFFSET_W-1:0] val);
    cfg_if.valid            <= 1'b1;
    cfg_if.line_offset_bits <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    line_off = val;
    settings_run++;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [ADDR_BITS-1:0] rand_wide();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_BITS-1:0];
  endfunction

  // mostly a few hot sets and a small tag pool so that hits and evictions happen
  function automatic logic [ADDR_BITS-1:0] pick_address();
    int unsigned pick;
    int unsigned s;
    int unsigned sh;
    logic [63:0] line;
    logic [63:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 10) return rand_wide();
    if (pick < 20) return last_addr;
    s    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SETS - 1)
                                       : hot_sets[$urandom_range(0, 3)];
    sh   = eff_shift();
    line = ({16'b0, tag_pool[$urandom_range(0, 11)]} << SET_BITS) | 64'(s);
    a    = (line << sh) | ({$urandom, $urandom} & ((64'd1 << sh) - 1));
    return a[ADDR_BITS-1:0];
  endfunction

  function automatic void new_phase_pools();
    for (int i = 0; i < 12; i++) tag_pool[i] = rand_wide();
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 0; i < 4; i++) hot_sets[i] = $urandom_range(0, SETS - 1);
    hot_sets[0] = 0;
    hot_sets[1] = SETS - 1;
  endfunction

  // result beats
  always @(posedge clk_i) begin
    lookup_t exp_res;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_if.hit) seen_hits++;
      else seen_misses++;
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0b way=%0d", $time, rsp_if.hit,
                 rsp_if.way_used);
        mismatches++;
      end else begin
        exp_res = pending_lookups.pop_front();
        if (rsp_if.hit !== exp_res.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_res.hit, rsp_if.hit);
          mismatches++;
        end
        if (rsp_if.way_used !== exp_res.way) begin
          $display("%0t: way_used expected %0d actual %0d", $time, exp_res.way,
                   rsp_if.way_used);
          mismatches++;
        end
        if (rsp_if.hit_total !== exp_res.hits) begin
          $display("%0t: hit_total expected %0d actual %0d", $time, exp_res.hits,
                   rsp_if.hit_total);
          mismatches++;
        end
        if (rsp_if.miss_total !== exp_res.misses) begin
          $display("%0t: miss_total expected %0d actual %0d", $time, exp_res.misses,
                   rsp_if.miss_total);
          mismatches++;
        end
      end
    end
  end

  // result sink with random stalls
  initial begin
    int unsigned stall;
    int unsigned beats;
    rsp_if.ready <= 1'b0;
    rsp_idle = 1'b1;
    beats    = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = rsp_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      beats++;
      if (beats % 64 == 0) rsp_idle = ($urandom_range(0, 2) != 0);
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_lookups.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned offset_settings [PHASE_N];
    lookup_t     typed_exp;
    rst_ni                  <= 1'b0;
    req_if.valid            <= 1'b0;
    req_if.address          <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.line_offset_bits <= '0;
    mismatches   = 0;
    seen_hits    = 0;
    seen_misses  = 0;
    settings_run = 1;
    req_idle     = 1'b1;
    last_addr    = '0;
    hit_cnt      = '0;
    miss_cnt     = '0;
    line_off     = LINE_OFFSET_RESET;
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        way_valid[s][w] = 1'b0;
        way_rank[s][w]  = 0;
        tag_mem[s][w]   = '0;
      end
    offset_settings = '{0, 12, 15, 13, 3, 9, 6, 0};
    offset_settings[PHASE_N-1] = $urandom_range(1, 11);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset line size
    for (int i = 0; i < DIR_N; i++) begin
      typed_exp = '{dir_rows[i].hit, dir_rows[i].way, dir_rows[i].hits, dir_rows[i].misses};
      send_lookup(dir_rows[i].addr, dir_rows[i].typed, typed_exp);
    end
    drain_lookups();

    for (int p = 0; p < PHASE_N; p++) begin
      write_line_offset(offset_settings[p][OFFSET_W-1:0]);
      new_phase_pools();
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (i % 40 == 0) req_idle = ($urandom_range(0, 3) != 0);
        send_lookup(pick_address(), 1'b0, '0);
      end
      drain_lookups();
    end

    repeat (10) @(posedge clk_i);
    $display("lookups checked: %0d hits, %0d misses, under %0d line-size settings",
             seen_hits, seen_misses, settings_run);
    $display("line sizes included 1 byte, 4 KiB and out-of-range settings");
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sacl_pkg.sv
design/sacl_if.sv
design/set_assoc_lru_cache_lookup_core.sv
tb/tb_top.sv
